/* sv/bsp_pkg.sv */
// Package for the block-shuffle pattern generator: sizes, register indexes,
// controller states, the command and status bundles and the symbol map.
// No dependencies; every other file of the block but bsp_ram imports it.
package bsp_pkg;

   localparam int MAX_TRIALS   = 2048;
   localparam int IDX_W        = $clog2(MAX_TRIALS);
   localparam int CNT_W        = IDX_W + 1;
   localparam int BLOCK_LIMIT  = 1024;
   localparam int BNUM_W       = $clog2(BLOCK_LIMIT);
   localparam int BLK_W        = BNUM_W + 1;
   localparam int WORD_W       = 31;
   localparam int SYM_W        = 8;
   localparam int RAM_W        = IDX_W + 1;
   localparam int DIV_STEPS    = WORD_W;
   localparam int DIV_CNT_W    = $clog2(DIV_STEPS);

   localparam int SYM_COUNT    = 62;
   localparam int SYM_IDX_W    = 6;
   localparam int RECIP        = 1057;
   localparam int RECIP_W      = 11;
   localparam int RECIP_SHIFT  = 16;
   localparam int QUOT_W       = 6;
   localparam int REM_RAW_W    = 7;

   localparam int CSR_INDEX_W  = 2;
   localparam int CSR_DATA_W   = 12;

   localparam logic [CSR_INDEX_W-1:0] CSR_TRIAL_COUNT = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_BLOCK_COUNT = 2'd1;

   localparam logic [CNT_W-1:0] TRIAL_COUNT_RESET = 12'd4;
   localparam logic [BLK_W-1:0] BLOCK_COUNT_RESET = 11'd1;

   localparam logic [SYM_W-1:0] CHAR_DOT     = 8'h2E;
   localparam logic [SYM_W-1:0] CHAR_UPPER_A = 8'h41;
   localparam logic [SYM_W-1:0] CHAR_LOWER_A = 8'h61;
   localparam logic [SYM_W-1:0] CHAR_ZERO    = 8'h30;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_DIV,
      ST_RD_POS,
      ST_RD_PIV,
      ST_WR_POS,
      ST_WR_PIV,
      ST_DONE
   } bsp_state_type;

   typedef struct packed {
      logic clr_wr;
      logic load_item;
      logic div_step;
      logic rd_pos;
      logic rd_piv;
      logic wr_pos;
      logic wr_piv;
      logic finish;
   } bsp_cmd_type;

   typedef struct packed {
      logic finished;
      logic rem_gt1;
      logic div_last;
      logic clr_last;
      logic out_empty;
   } bsp_status_type;

   function automatic logic [SYM_W-1:0] sym_char(input logic [SYM_IDX_W-1:0] r);
      logic [SYM_W-1:0] r_ext;
      r_ext = {{(SYM_W-SYM_IDX_W){1'b0}}, r};
      if (r_ext < 8'd26) begin
         sym_char = CHAR_UPPER_A + r_ext;
      end else if (r_ext < 8'd52) begin
         sym_char = CHAR_LOWER_A + (r_ext - 8'd26);
      end else begin
         sym_char = CHAR_ZERO + (r_ext - 8'd52);
      end
   endfunction

endpackage

/* sv/bsp_if.sv */
// Channel interfaces of the block-shuffle pattern generator: request,
// response and register write channels. Depends on bsp_pkg.
interface bsp_req_if;
   import bsp_pkg::*;
   logic              valid;
   logic              ready;
   logic [WORD_W-1:0] random_word;
   modport source (output valid, output random_word, input ready);
   modport sink (input valid, input random_word, output ready);
endinterface

interface bsp_rsp_if;
   import bsp_pkg::*;
   logic             valid;
   logic             ready;
   logic [SYM_W-1:0] symbol;
   logic             end_of_block;
   logic             end_of_session;
   logic             last_of_item;
   modport source (output valid, output symbol, output end_of_block,
                   output end_of_session, output last_of_item, input ready);
   modport sink (input valid, input symbol, input end_of_block,
                 input end_of_session, input last_of_item, output ready);
endinterface

interface bsp_csr_if;
   import bsp_pkg::*;
   logic                   valid;
   logic                   ready;
   logic [CSR_INDEX_W-1:0] index;
   logic [CSR_DATA_W-1:0]  data;
   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

/* sv/bsp_ram.sv */
// Generic simple dual-port RAM: one write port and one read port with
// registered read data. No dependencies.
module bsp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* sv/bsp_ctrl.sv */
// Controller state machine of the block-shuffle pattern generator. It
// sequences the datapath through commands. Depends on bsp_pkg.
module bsp_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  bsp_pkg::bsp_status_type status,
   output bsp_pkg::bsp_cmd_type    cmd
);
   import bsp_pkg::*;

   bsp_state_type state_ff;
   bsp_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_CLEAR: begin
            cmd.clr_wr = 1'b1;
            if (status.clr_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid && !status.finished) begin
               cmd.load_item = 1'b1;
               state_in = status.rem_gt1 ? ST_DIV : ST_RD_POS;
            end
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (status.div_last) begin
               state_in = ST_RD_POS;
            end
         end
         ST_RD_POS: begin
            cmd.rd_pos = 1'b1;
            state_in = ST_RD_PIV;
         end
         ST_RD_PIV: begin
            cmd.rd_piv = 1'b1;
            state_in = ST_WR_POS;
         end
         ST_WR_POS: begin
            cmd.wr_pos = 1'b1;
            state_in = ST_WR_PIV;
         end
         ST_WR_PIV: begin
            cmd.wr_piv = 1'b1;
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (status.out_empty) begin
               cmd.finish = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

/* sv/bsp_datapath.sv */
// Datapath of the block-shuffle pattern generator: registers, bit-serial
// remainder unit, index table, symbol mapping and response buffer.
// Depends on bsp_pkg and bsp_ram.
module bsp_datapath (
   input  logic                           clock,
   input  logic                           reset,
   input  bsp_pkg::bsp_cmd_type           cmd,
   output bsp_pkg::bsp_status_type        status,
   input  logic [bsp_pkg::WORD_W-1:0]     random_word,
   input  logic                           csr_we,
   input  logic [bsp_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [bsp_pkg::CSR_DATA_W-1:0] csr_data,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [bsp_pkg::SYM_W-1:0]      rsp_symbol,
   output logic                           rsp_eob,
   output logic                           rsp_eos,
   output logic                           rsp_last
);
   import bsp_pkg::*;

   logic [CNT_W-1:0]     trial_count_ff, trial_count_in;
   logic [BLK_W-1:0]     block_count_ff, block_count_in;
   logic [IDX_W-1:0]     pos_ff, pos_in;
   logic [BNUM_W-1:0]    block_num_ff, block_num_in;
   logic                 gen_ff, gen_in;
   logic                 finished_ff, finished_in;
   logic [IDX_W-1:0]     clr_cnt_ff, clr_cnt_in;
   logic                 dot_pend_ff, dot_pend_in;
   logic                 sym_pend_ff, sym_pend_in;

   logic [WORD_W-1:0]    word_ff, word_in;
   logic [CNT_W-1:0]     rem_ff, rem_in;
   logic [IDX_W-1:0]     part_ff, part_in;
   logic [DIV_CNT_W-1:0] div_cnt_ff, div_cnt_in;
   logic [IDX_W-1:0]     piv_ff, piv_in;
   logic [IDX_W-1:0]     a_ff, a_in;
   logic [IDX_W-1:0]     b_ff, b_in;
   logic [QUOT_W-1:0]    q_ff, q_in;
   logic                 eob_ff, eob_in;
   logic                 eos_ff, eos_in;
   logic                 dot_ff, dot_in;
   logic [SYM_W-1:0]     out_sym_ff, out_sym_in;
   logic                 out_eob_ff, out_eob_in;
   logic                 out_eos_ff, out_eos_in;

   logic [CNT_W-1:0]           n_eff;
   logic [BLK_W-1:0]           b_eff;
   logic [CNT_W-1:0]           pos_ext;
   logic [CNT_W-1:0]           rem_now;
   logic                       eob_now;
   logic                       eos_now;
   logic [CNT_W-1:0]           div_trial;
   logic [CNT_W-1:0]           div_next;
   logic [IDX_W+RECIP_W-1:0]   q_prod;
   logic [IDX_W-1:0]           r_full;
   logic [REM_RAW_W-1:0]       r_raw;
   logic [SYM_IDX_W-1:0]       r_fix;
   logic                       ram_we;
   logic [IDX_W-1:0]           ram_wr_addr;
   logic [RAM_W-1:0]           ram_wr_data;
   logic [IDX_W-1:0]           ram_rd_addr;
   logic [RAM_W-1:0]           ram_rd_data;
   logic [IDX_W-1:0]           rd_val_pos;
   logic [IDX_W-1:0]           rd_val_piv;

   bsp_ram #(
      .WIDTH (RAM_W),
      .DEPTH (MAX_TRIALS)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // An entry whose tag is not the current generation reads as its address.
   assign rd_val_pos = (ram_rd_data[RAM_W-1] != gen_ff) ? pos_ff : ram_rd_data[IDX_W-1:0];
   assign rd_val_piv = (ram_rd_data[RAM_W-1] != gen_ff) ? piv_ff : ram_rd_data[IDX_W-1:0];

   assign ram_rd_addr = cmd.rd_pos ? pos_ff : piv_ff;
   assign ram_we      = cmd.clr_wr | cmd.wr_pos | cmd.wr_piv;
   assign ram_wr_addr = cmd.clr_wr ? clr_cnt_ff : (cmd.wr_pos ? pos_ff : piv_ff);
   assign ram_wr_data = cmd.clr_wr ? '0 :
                        (cmd.wr_pos ? {gen_ff, rd_val_piv} : {gen_ff, a_ff});

   always_comb begin
      if (trial_count_ff == '0) begin
         n_eff = CNT_W'(1);
      end else if (trial_count_ff > CNT_W'(MAX_TRIALS)) begin
         n_eff = CNT_W'(MAX_TRIALS);
      end else begin
         n_eff = trial_count_ff;
      end
      if (block_count_ff == '0) begin
         b_eff = BLK_W'(1);
      end else if (block_count_ff > BLK_W'(BLOCK_LIMIT)) begin
         b_eff = BLK_W'(BLOCK_LIMIT);
      end else begin
         b_eff = block_count_ff;
      end
   end

   assign pos_ext = {1'b0, pos_ff};
   assign rem_now = (pos_ext < n_eff) ? (n_eff - pos_ext) : CNT_W'(1);
   assign eob_now = (pos_ext + CNT_W'(1)) >= n_eff;
   assign eos_now = eob_now && (({1'b0, block_num_ff} + BLK_W'(1)) >= b_eff);

   assign div_trial = {part_ff, word_ff[WORD_W-1]};
   assign div_next  = (div_trial >= rem_ff) ? (div_trial - rem_ff) : div_trial;

   assign q_prod = b_ff * RECIP_W'(RECIP);
   assign r_full = b_ff - (IDX_W'(q_ff) * IDX_W'(SYM_COUNT));
   assign r_raw  = r_full[REM_RAW_W-1:0];
   assign r_fix  = (r_raw >= REM_RAW_W'(SYM_COUNT)) ?
                   SYM_IDX_W'(r_raw - REM_RAW_W'(SYM_COUNT)) : SYM_IDX_W'(r_raw);

   assign status.finished  = finished_ff;
   assign status.rem_gt1   = rem_now > CNT_W'(1);
   assign status.div_last  = div_cnt_ff == DIV_CNT_W'(DIV_STEPS - 1);
   assign status.clr_last  = &clr_cnt_ff;
   assign status.out_empty = !dot_pend_ff && !sym_pend_ff;

   assign rsp_valid  = dot_pend_ff | sym_pend_ff;
   assign rsp_symbol = dot_pend_ff ? CHAR_DOT : out_sym_ff;
   assign rsp_eob    = !dot_pend_ff && out_eob_ff;
   assign rsp_eos    = !dot_pend_ff && out_eos_ff;
   assign rsp_last   = !dot_pend_ff;

   always_comb begin
      trial_count_in = trial_count_ff;
      block_count_in = block_count_ff;
      pos_in         = pos_ff;
      block_num_in   = block_num_ff;
      gen_in         = gen_ff;
      finished_in    = finished_ff;
      clr_cnt_in     = clr_cnt_ff;
      dot_pend_in    = dot_pend_ff;
      sym_pend_in    = sym_pend_ff;
      word_in        = word_ff;
      rem_in         = rem_ff;
      part_in        = part_ff;
      div_cnt_in     = div_cnt_ff;
      piv_in         = piv_ff;
      a_in           = a_ff;
      b_in           = b_ff;
      q_in           = q_ff;
      eob_in         = eob_ff;
      eos_in         = eos_ff;
      dot_in         = dot_ff;
      out_sym_in     = out_sym_ff;
      out_eob_in     = out_eob_ff;
      out_eos_in     = out_eos_ff;

      if (csr_we) begin
         case (csr_index)
            CSR_TRIAL_COUNT: trial_count_in = csr_data[CNT_W-1:0];
            CSR_BLOCK_COUNT: block_count_in = csr_data[BLK_W-1:0];
            default: ;
         endcase
      end

      if (cmd.clr_wr) begin
         clr_cnt_in = clr_cnt_ff + IDX_W'(1);
      end

      if (cmd.load_item) begin
         word_in    = random_word;
         rem_in     = rem_now;
         part_in    = '0;
         div_cnt_in = '0;
         eob_in     = eob_now;
         eos_in     = eos_now;
         dot_in     = pos_ff == '0;
      end

      if (cmd.div_step) begin
         part_in    = div_next[IDX_W-1:0];
         word_in    = {word_ff[WORD_W-2:0], 1'b0};
         div_cnt_in = div_cnt_ff + DIV_CNT_W'(1);
      end

      if (cmd.rd_pos) begin
         piv_in = pos_ff + part_ff;
      end

      if (cmd.rd_piv) begin
         a_in = rd_val_pos;
      end

      if (cmd.wr_pos) begin
         b_in = rd_val_piv;
      end

      if (cmd.wr_piv) begin
         q_in = q_prod[RECIP_SHIFT +: QUOT_W];
      end

      if (rsp_valid && rsp_ready) begin
         if (dot_pend_ff) begin
            dot_pend_in = 1'b0;
         end else begin
            sym_pend_in = 1'b0;
         end
      end

      if (cmd.finish) begin
         dot_pend_in = dot_ff;
         sym_pend_in = 1'b1;
         out_sym_in  = sym_char(r_fix);
         out_eob_in  = eob_ff;
         out_eos_in  = eos_ff;
         if (eob_ff) begin
            pos_in = '0;
            gen_in = ~gen_ff;
            if (eos_ff) begin
               finished_in = 1'b1;
            end else begin
               block_num_in = block_num_ff + BNUM_W'(1);
            end
         end else begin
            pos_in = pos_ff + IDX_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         trial_count_ff <= TRIAL_COUNT_RESET;
         block_count_ff <= BLOCK_COUNT_RESET;
         pos_ff         <= '0;
         block_num_ff   <= '0;
         gen_ff         <= 1'b1;
         finished_ff    <= 1'b0;
         clr_cnt_ff     <= '0;
         dot_pend_ff    <= 1'b0;
         sym_pend_ff    <= 1'b0;
      end else begin
         trial_count_ff <= trial_count_in;
         block_count_ff <= block_count_in;
         pos_ff         <= pos_in;
         block_num_ff   <= block_num_in;
         gen_ff         <= gen_in;
         finished_ff    <= finished_in;
         clr_cnt_ff     <= clr_cnt_in;
         dot_pend_ff    <= dot_pend_in;
         sym_pend_ff    <= sym_pend_in;
      end
   end

   always_ff @(posedge clock) begin
      word_ff    <= word_in;
      rem_ff     <= rem_in;
      part_ff    <= part_in;
      div_cnt_ff <= div_cnt_in;
      piv_ff     <= piv_in;
      a_ff       <= a_in;
      b_ff       <= b_in;
      q_ff       <= q_in;
      eob_ff     <= eob_in;
      eos_ff     <= eos_in;
      dot_ff     <= dot_in;
      out_sym_ff <= out_sym_in;
      out_eob_ff <= out_eob_in;
      out_eos_ff <= out_eos_in;
   end

   a_dot_has_symbol: assert property (@(posedge clock) disable iff (reset)
      dot_pend_ff |-> sym_pend_ff)
      else $error("separator pending without its trial symbol");

   a_finish_into_empty: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |-> (!dot_pend_ff && !sym_pend_ff))
      else $error("response buffer overwritten");

   a_pivot_range: assert property (@(posedge clock) disable iff (reset)
      cmd.rd_pos |-> (({1'b0, part_ff} < rem_ff) || (part_ff == '0)))
      else $error("pivot offset out of range");

   a_gen_flip: assert property (@(posedge clock) disable iff (reset)
      (gen_ff != $past(gen_ff)) |-> $past(cmd.finish && eob_ff))
      else $error("generation changed outside a block end");

endmodule

/* sv/blockwise_shuffle_pattern_generator.sv */
// Top level of the block-shuffle pattern generator: controller, datapath
// and channel wiring. Depends on bsp_pkg, bsp_if, bsp_ctrl, bsp_datapath.
//
//   Channel   Direction  Contents
//   req_if    in         random_word (31 bits), one per request
//   rsp_if    out        symbol, end_of_block, end_of_session, last_of_item
//   csr_if    in         index 0 = trial_count, index 1 = block_count
//
// A request runs the bit-serial remainder unit, then the read, write and done
// states before the next ready; at a block's last position it skips the unit.
// After reset a clearing pass sweeps all 2048 entries of the index table, one
// entry per cycle, with req ready low; register writes are taken throughout.
// Responses sit in a two-entry buffer, so a stalled response side holds the
// block only at the end of the following request.
module blockwise_shuffle_pattern_generator (
   input logic         clock,
   input logic         reset,
   bsp_req_if.sink     req_if,
   bsp_rsp_if.source   rsp_if,
   bsp_csr_if.sink     csr_if
);
   import bsp_pkg::*;

   bsp_cmd_type    cmd;
   bsp_status_type status;

   assign csr_if.ready = 1'b1;

   bsp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_if.ready),
      .status    (status),
      .cmd       (cmd)
   );

   bsp_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .status      (status),
      .random_word (req_if.random_word),
      .csr_we      (csr_if.valid),
      .csr_index   (csr_if.index),
      .csr_data    (csr_if.data),
      .rsp_valid   (rsp_if.valid),
      .rsp_ready   (rsp_if.ready),
      .rsp_symbol  (rsp_if.symbol),
      .rsp_eob     (rsp_if.end_of_block),
      .rsp_eos     (rsp_if.end_of_session),
      .rsp_last    (rsp_if.last_of_item)
   );

endmodule
